>>> src/spq_pkg.sv
// shared types and constants for the sorted priority queue with wait report
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH    = 32;
  localparam int MAX_OUT  = 32;
  localparam int REP_MAX  = (MAX_OUT < DEPTH) ? MAX_OUT : DEPTH;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 16;
  localparam int BURST_W  = 16;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int WAIT_W   = 21;
  localparam int TOT_W    = 26;
  localparam int ENT_W    = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the command operands, clear report accumulators
    logic insert;  // shift-insert into the cell chain and give the result
    logic match;   // register the id match vector
    logic remove;  // close the gap at the first match and give the result
    logic step;    // give one report result and advance
  } ctl_t;

endpackage

>>> src/spq_ctrl.sv
// controller state machine for the sorted priority queue
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_ctrl import spq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CMD_W-1:0] cmd,
  input  logic             rep_last,
  output logic             busy,
  output ctl_t             ctl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INS    = 5'b00010,
    S_MATCH  = 5'b00100,
    S_APPLY  = 5'b01000,
    S_REPORT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          case (cmd_t'(cmd))
            CMD_INSERT: state_next = S_INS;
            CMD_DELETE: state_next = S_MATCH;
            CMD_REPORT: state_next = S_REPORT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        ctl.insert = 1'b1;
        state_next = S_IDLE;
      end
      S_MATCH: begin
        ctl.match  = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        ctl.remove = 1'b1;
        state_next = S_IDLE;
      end
      S_REPORT: begin
        ctl.step = 1'b1;
        if (rep_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> src/spq_dpath.sv
// datapath: sorted cell chain, id match, report accumulators, result registers
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_dpath import spq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctl_t                ctl,
  input  logic [ID_W-1:0]     proc_id,
  input  logic [BURST_W-1:0]  burst,
  input  logic [PRIO_W-1:0]   prio,
  output logic                rep_last,
  output logic                valid,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     out_id,
  output logic [BURST_W-1:0]  out_burst,
  output logic [PRIO_W-1:0]   out_prio,
  output logic [WAIT_W-1:0]   waiting,
  output logic [WAIT_W-1:0]   turnaround,
  output logic [TOT_W-1:0]    total_waiting,
  output logic [TOT_W-1:0]    total_turnaround,
  output logic [ENT_W-1:0]    entry_total,
  output logic                last
);

  entry_t             in_e;
  entry_t             q [DEPTH];
  entry_t             up_src [DEPTH];
  entry_t             dn_src [DEPTH];
  logic [CNT_W-1:0]   count;
  logic [DEPTH-1:0]   hit;
  logic [DEPTH-1:0]   hit_next;
  logic [IDX_W-1:0]   idx;
  logic [WAIT_W-1:0]  wt;
  logic [TOT_W-1:0]   twt;
  logic [TOT_W-1:0]   tta;

  logic               full;
  logic               found;
  logic [DEPTH-1:0]   ge;
  logic [DEPTH-1:0]   prev_ge;
  logic [DEPTH-1:0]   neg_hit;
  logic [DEPTH-1:0]   after_hit;
  logic [DEPTH-1:0]   first_hit;
  entry_t             gone;
  entry_t             sel;
  logic [CNT_W-1:0]   n_rep;
  logic [WAIT_W-1:0]  ta;
  logic [TOT_W-1:0]   twt_new;
  logic [TOT_W-1:0]   tta_new;

  assign full  = (count == CNT_W'(DEPTH));
  assign found = |hit;

  // insert position: first held cell whose priority is not below the new one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i]       = (CNT_W'(i) >= count) || (q[i].prio >= in_e.prio);
      hit_next[i] = (CNT_W'(i) < count) && (q[i].id == in_e.id);
    end
  end

  assign prev_ge = {ge[DEPTH-2:0], 1'b0};

  // lowest set bit and everything above it, by two's complement
  assign neg_hit   = ~hit + {{(DEPTH-1){1'b0}}, 1'b1};
  assign after_hit = hit | neg_hit;
  assign first_hit = hit & neg_hit;

  always_comb begin
    gone = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hit[i]) begin
        gone = gone | q[i];
      end
    end
  end

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign up_src[g] = in_e;
    end else begin : g_body
      assign up_src[g] = q[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign dn_src[g] = q[g];
    end else begin : g_inner
      assign dn_src[g] = q[g+1];
    end

    always_ff @(posedge clk) begin
      if (ctl.insert && !full) begin
        if (ge[g]) begin
          q[g] <= prev_ge[g] ? up_src[g] : in_e;
        end
      end else if (ctl.remove && after_hit[g]) begin
        q[g] <= dn_src[g];
      end
    end
  end

  // report walk
  assign sel      = q[idx];
  assign n_rep    = (count < CNT_W'(REP_MAX)) ? count : CNT_W'(REP_MAX);
  assign rep_last = (count == '0) || (CNT_W'(idx) == n_rep - 1'b1);
  assign ta       = wt + WAIT_W'(sel.burst);
  assign twt_new  = twt + TOT_W'(wt);
  assign tta_new  = tta + TOT_W'(wt) + TOT_W'(sel.burst);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.insert && !full) begin
      count <= count + 1'b1;
    end else if (ctl.remove && found) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.match) begin
      hit <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_e <= '{id: proc_id, burst: burst, prio: prio};
      idx  <= '0;
      wt   <= '0;
      twt  <= '0;
      tta  <= '0;
    end else if (ctl.step) begin
      idx <= idx + 1'b1;
      wt  <= ta;
      twt <= twt_new;
      tta <= tta_new;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctl.insert | ctl.remove | ctl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      status           <= full ? ST_FULL : ST_OK;
      out_id           <= in_e.id;
      out_burst        <= in_e.burst;
      out_prio         <= in_e.prio;
      waiting          <= '0;
      turnaround       <= '0;
      total_waiting    <= '0;
      total_turnaround <= '0;
      entry_total      <= full ? ENT_W'(count) : ENT_W'(count + 1'b1);
      last             <= 1'b1;
    end else if (ctl.remove) begin
      status           <= found ? ST_OK : ST_MISSING;
      out_id           <= found ? gone.id : in_e.id;
      out_burst        <= found ? gone.burst : '0;
      out_prio         <= found ? gone.prio : '0;
      waiting          <= '0;
      turnaround       <= '0;
      total_waiting    <= '0;
      total_turnaround <= '0;
      entry_total      <= found ? ENT_W'(count - 1'b1) : ENT_W'(count);
      last             <= 1'b1;
    end else if (ctl.step) begin
      if (count == '0) begin
        status           <= ST_EMPTY;
        out_id           <= '0;
        out_burst        <= '0;
        out_prio         <= '0;
        waiting          <= '0;
        turnaround       <= '0;
        total_waiting    <= '0;
        total_turnaround <= '0;
        entry_total      <= '0;
      end else begin
        status           <= ST_OK;
        out_id           <= sel.id;
        out_burst        <= sel.burst;
        out_prio         <= sel.prio;
        waiting          <= wt;
        turnaround       <= ta;
        total_waiting    <= rep_last ? twt_new : '0;
        total_turnaround <= rep_last ? tta_new : '0;
        entry_total      <= rep_last ? ENT_W'(count) : '0;
      end
      last <= rep_last;
    end
  end

endmodule

>>> src/sorted_priority_queue_with_wait_report_unit.sv
// top level of the sorted priority queue with wait report
// depends on spq_pkg, spq_ctrl, spq_dpath
`timescale 1ns / 1ps

// A command is taken at a rising edge where start is high and busy is low.
// Results come out on registered ports, each marked by valid for exactly one
// cycle; there is no way to hold them off, so the receiver must take every
// result in the cycle it appears. Insert: one result, registered from the
// S_INS state, in which busy is high. Delete: one result, after S_MATCH
// registers the id match vector over the cell chain and S_APPLY closes the
// gap, with busy high in both states. Report: results are registered from
// the S_REPORT state and follow in consecutive cycles, one per held entry
// from the head, up to the report limit, with last marking the final one;
// busy stays high while the single read port walks the cells, and an
// empty queue gives a single result. A new command may be taken in the
// cycle after busy falls, while the final result is still on the ports.
// cmd 3 is taken and ignored. The cell contents need no clearing after
// reset: only the cells below the held count are ever looked at.

module sorted_priority_queue_with_wait_report_unit import spq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [ID_W-1:0]     proc_id,
  input  logic [BURST_W-1:0]  burst,
  input  logic [PRIO_W-1:0]   prio,
  output logic                valid,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     out_id,
  output logic [BURST_W-1:0]  out_burst,
  output logic [PRIO_W-1:0]   out_prio,
  output logic [WAIT_W-1:0]   waiting,
  output logic [WAIT_W-1:0]   turnaround,
  output logic [TOT_W-1:0]    total_waiting,
  output logic [TOT_W-1:0]    total_turnaround,
  output logic [ENT_W-1:0]    entry_total,
  output logic                last
);

  // command bundle from the controller, report end flag back from the datapath
  ctl_t ctl;
  logic rep_last;

  // sequencing of each transaction
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .rep_last (rep_last),
    .busy     (busy),
    .ctl      (ctl)
  );

  // cell chain, match logic, wait accumulators and result registers
  spq_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .proc_id          (proc_id),
    .burst            (burst),
    .prio             (prio),
    .rep_last         (rep_last),
    .valid            (valid),
    .status           (status),
    .out_id           (out_id),
    .out_burst        (out_burst),
    .out_prio         (out_prio),
    .waiting          (waiting),
    .turnaround       (turnaround),
    .total_waiting    (total_waiting),
    .total_turnaround (total_turnaround),
    .entry_total      (entry_total),
    .last             (last)
  );

endmodule

>>> src/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_with_wait_report_unit
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic [CMD_W-1:0]    cmd,
  input logic                valid,
  input logic [STATUS_W-1:0] status,
  input logic [ENT_W-1:0]    entry_total,
  input logic                last
);

  // a report never pauses between its results
  a_report_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |=> valid)
    else $error("report results not contiguous");

  // more results pending means no new transaction can be taken
  a_busy_while_pending: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |-> busy)
    else $error("idle with report results outstanding");

  // a taken command other than the unused code keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd != CMD_NONE) |=> busy)
    else $error("not busy after a transaction was taken");

  // an empty report is a single closing result with no entries
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (valid && status == ST_EMPTY) |-> (last && entry_total == '0))
    else $error("empty report result malformed");

  // a refused insert only happens with the queue at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (valid && status == ST_FULL) |-> (last && entry_total == ENT_W'(DEPTH)))
    else $error("full status with queue below capacity");

endmodule

bind sorted_priority_queue_with_wait_report_unit spq_checker u_spq_checker (.*);

>>> tb/tb.sv
// testbench for the sorted priority queue with wait report: drives commands,
// predicts every result in a scoreboard class and checks each one as it appears
// depends on spq_pkg and sorted_priority_queue_with_wait_report_unit
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  // one result as it appears on the output ports
  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     out_id;
    logic [BURST_W-1:0]  out_burst;
    logic [PRIO_W-1:0]   out_prio;
    logic [WAIT_W-1:0]   waiting;
    logic [WAIT_W-1:0]   turnaround;
    logic [TOT_W-1:0]    total_waiting;
    logic [TOT_W-1:0]    total_turnaround;
    logic [ENT_W-1:0]    entry_total;
    logic                last;
  } result_t;

  // mix of commands used by the random part
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  // scoreboard: keeps its own copy of the queue, works out the results of
  // every accepted transaction and compares them with what the block gives
  class wait_report_checker;
    entry_t  held[DEPTH];
    int      held_count;
    result_t due_results[$];
    int      mismatches;
    int      checked;
    int      peak_fill;
    int      n_insert, n_full, n_delete, n_missing, n_report, n_empty, n_ignored;

    function new();
      held_count = 0;
      mismatches = 0;
      checked    = 0;
      peak_fill  = 0;
      n_insert = 0; n_full = 0; n_delete = 0; n_missing = 0;
      n_report = 0; n_empty = 0; n_ignored = 0;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function logic [ID_W-1:0] held_id(int k);
      return held[k].id;
    endfunction

    // update the queue copy for one accepted command and queue its results
    function void take_command(cmd_t op, logic [ID_W-1:0] id,
                               logic [BURST_W-1:0] bu, logic [PRIO_W-1:0] pr);
      result_t     r;
      entry_t      gone;
      int          pos;
      int          n;
      int unsigned wt, ta, twt, tta;
      r = '0;
      r.last = 1'b1;
      case (op)
        CMD_INSERT: begin
          n_insert++;
          r.out_id    = id;
          r.out_burst = bu;
          r.out_prio  = pr;
          if (held_count >= DEPTH) begin
            n_full++;
            r.status = ST_FULL;
          end else begin
            pos = 0;
            // goes ahead of the first entry with equal or greater priority
            while (pos < held_count && pr > held[pos].prio) pos++;
            for (int i = held_count; i > pos; i--) held[i] = held[i-1];
            held[pos].id    = id;
            held[pos].burst = bu;
            held[pos].prio  = pr;
            held_count++;
            if (held_count > peak_fill) peak_fill = held_count;
            r.status = ST_OK;
          end
          r.entry_total = ENT_W'(held_count);
          due_results.push_back(r);
        end
        CMD_DELETE: begin
          n_delete++;
          pos = 0;
          while (pos < held_count && held[pos].id != id) pos++;
          if (pos >= held_count) begin
            n_missing++;
            r.status = ST_MISSING;
            r.out_id = id;
          end else begin
            gone = held[pos];
            for (int i = pos; i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
            r.status    = ST_OK;
            r.out_id    = gone.id;
            r.out_burst = gone.burst;
            r.out_prio  = gone.prio;
          end
          r.entry_total = ENT_W'(held_count);
          due_results.push_back(r);
        end
        CMD_REPORT: begin
          n_report++;
          n = (held_count < REP_MAX) ? held_count : REP_MAX;
          if (n == 0) begin
            n_empty++;
            r.status = ST_EMPTY;
            due_results.push_back(r);
          end else begin
            wt = 0; twt = 0; tta = 0;
            for (int i = 0; i < n; i++) begin
              ta  = wt + held[i].burst;
              twt += wt;
              tta += ta;
              r = '0;
              r.status     = ST_OK;
              r.out_id     = held[i].id;
              r.out_burst  = held[i].burst;
              r.out_prio   = held[i].prio;
              r.waiting    = WAIT_W'(wt);
              r.turnaround = WAIT_W'(ta);
              if (i + 1 == n) begin
                r.total_waiting    = TOT_W'(twt);
                r.total_turnaround = TOT_W'(tta);
                r.entry_total      = ENT_W'(held_count);
                r.last             = 1'b1;
              end
              due_results.push_back(r);
              wt = ta;
            end
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    function string fmt(result_t r);
      return $sformatf({"st=%0d id=%h bu=%h pr=%h wt=%0d ta=%0d twt=%0d tta=%0d",
                        " cnt=%0d last=%b"}, r.status, r.out_id, r.out_burst,
                       r.out_prio, r.waiting, r.turnaround, r.total_waiting,
                       r.total_turnaround, r.entry_total, r.last);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      checked++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: unexpected result %s", fmt(got));
      end else begin
        exp = due_results.pop_front();
        if (got.status !== exp.status || got.out_id !== exp.out_id ||
            got.out_burst !== exp.out_burst || got.out_prio !== exp.out_prio ||
            got.waiting !== exp.waiting || got.turnaround !== exp.turnaround ||
            got.total_waiting !== exp.total_waiting ||
            got.total_turnaround !== exp.total_turnaround ||
            got.entry_total !== exp.entry_total || got.last !== exp.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected %s", $realtime, fmt(exp));
            $display("                 got      %s", fmt(got));
          end
        end
      end
    endfunction
  endclass

  // block ports; the inputs are known from time zero
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    cmd = '0;
  logic [ID_W-1:0]     proc_id = '0;
  logic [BURST_W-1:0]  burst = '0;
  logic [PRIO_W-1:0]   prio = '0;
  logic                valid;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_id;
  logic [BURST_W-1:0]  out_burst;
  logic [PRIO_W-1:0]   out_prio;
  logic [WAIT_W-1:0]   waiting;
  logic [WAIT_W-1:0]   turnaround;
  logic [TOT_W-1:0]    total_waiting;
  logic [TOT_W-1:0]    total_turnaround;
  logic [ENT_W-1:0]    entry_total;
  logic                last;

  wait_report_checker sb;
  int                 idle_pct;   // chance in a hundred that the sender idles a cycle

  sorted_priority_queue_with_wait_report_unit dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .cmd              (cmd),
    .proc_id          (proc_id),
    .burst            (burst),
    .prio             (prio),
    .valid            (valid),
    .status           (status),
    .out_id           (out_id),
    .out_burst        (out_burst),
    .out_prio         (out_prio),
    .waiting          (waiting),
    .turnaround       (turnaround),
    .total_waiting    (total_waiting),
    .total_turnaround (total_turnaround),
    .entry_total      (entry_total),
    .last             (last)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // results cannot be held off, so every strobed cycle is a transaction;
  // outputs are read at the edge, before the block updates them
  always @(posedge clk) begin
    result_t got;
    if (!rst && valid) begin
      got.status           = status_t'(status);
      got.out_id           = out_id;
      got.out_burst        = out_burst;
      got.out_prio         = out_prio;
      got.waiting          = waiting;
      got.turnaround       = turnaround;
      got.total_waiting    = total_waiting;
      got.total_turnaround = total_turnaround;
      got.entry_total      = entry_total;
      got.last             = last;
      sb.check_result(got);
    end
  end

  // present one command and hold it until the block takes it; start stays
  // high on return so a back-to-back command needs no second assignment
  task automatic issue(cmd_t op, logic [ID_W-1:0] id, logic [BURST_W-1:0] bu,
                       logic [PRIO_W-1:0] pr);
    cmd     <= op;
    proc_id <= id;
    burst   <= bu;
    prio    <= pr;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sb.take_command(op, id, bu, pr);
  endtask

  // random idle cycles between transactions
  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold off until every expected result has come, plus a short margin
  task automatic settle();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // small id pool gives duplicate ids, so delete must pick the one nearest the head
  function automatic logic [ID_W-1:0] rand_id();
    return ($urandom_range(3) == 0) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
  endfunction

  // all-ones bursts push the waiting sums towards the top of their range
  function automatic logic [BURST_W-1:0] rand_burst();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) return '1;
    if (roll < 30) return '0;
    return BURST_W'($urandom);
  endfunction

  // a few coarse levels make equal priorities common
  function automatic logic [PRIO_W-1:0] rand_prio();
    return ($urandom_range(9) < 3) ? PRIO_W'($urandom_range(3) * 85) : PRIO_W'($urandom);
  endfunction

  // one random command, weighted by the current mix
  task automatic random_command(mix_t mix);
    int unsigned roll;
    int          ins_cut, del_cut;
    logic [ID_W-1:0] id;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin ins_cut = 75; del_cut = 85; end
      MIX_DRAIN: begin ins_cut = 20; del_cut = 75; end
      default:   begin ins_cut = 45; del_cut = 75; end
    endcase
    sender_gap();
    if (roll < ins_cut) begin
      issue(CMD_INSERT, rand_id(), rand_burst(), rand_prio());
    end else if (roll < del_cut) begin
      // mostly ids that are held, the rest most likely missing
      if (sb.held_count > 0 && $urandom_range(3) != 0)
        id = sb.held_id($urandom_range(sb.held_count - 1));
      else
        id = rand_id();
      issue(CMD_DELETE, id, BURST_W'($urandom), PRIO_W'($urandom));
    end else if (roll < 97) begin
      issue(CMD_REPORT, ID_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
    end else begin
      issue(CMD_NONE, ID_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
    end
  endtask

  // fill to the limit, try one more insert, then report the full queue
  task automatic fill_and_report();
    while (sb.held_count < DEPTH) begin
      sender_gap();
      issue(CMD_INSERT, rand_id(), rand_burst(), rand_prio());
    end
    sender_gap();
    issue(CMD_INSERT, rand_id(), rand_burst(), rand_prio());
    sender_gap();
    issue(CMD_REPORT, '0, '0, '0);
  endtask

  // one phase of the random part: a full-queue run, then shifting mixes
  task automatic random_phase(int count);
    mix_t mix;
    fill_and_report();
    for (int i = 0; i < count; i++) begin
      case ((i / 30) % 4)
        0:       mix = MIX_DRAIN;
        1:       mix = MIX_EVEN;
        2:       mix = MIX_FILL;
        default: mix = MIX_EVEN;
      endcase
      random_command(mix);
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 19;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part: empty queue cases first
    issue(CMD_REPORT, '0, '0, '0);
    issue(CMD_DELETE, 16'h1234, '0, '0);
    issue(CMD_NONE, '1, '1, '1);
    // field extremes and ordering among equal priorities
    issue(CMD_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF);
    issue(CMD_INSERT, 16'h0000, 16'h0000, 8'h00);
    issue(CMD_INSERT, 16'h00A5, 16'd100, 8'hFF);
    issue(CMD_INSERT, 16'h5A00, 16'd30, 8'h80);
    issue(CMD_INSERT, 16'h0001, 16'h0001, 8'h00);
    issue(CMD_INSERT, 16'hFFFF, 16'h0007, 8'h10);
    issue(CMD_REPORT, '0, '0, '0);
    // duplicate id goes from the head, then a missing id, then the middle
    issue(CMD_DELETE, 16'hFFFF, '0, '0);
    issue(CMD_DELETE, 16'h4321, '1, '1);
    issue(CMD_DELETE, 16'h0000, '0, '0);
    issue(CMD_REPORT, '0, '0, '0);
    // ignored command must leave the queue alone
    issue(CMD_NONE, 16'h0001, '0, '0);
    issue(CMD_REPORT, '0, '0, '0);
    // head and tail removal
    issue(CMD_DELETE, 16'h0001, '0, '0);
    issue(CMD_DELETE, 16'hFFFF, '0, '0);
    issue(CMD_REPORT, '0, '0, '0);
    settle();

    // random part in three idling phases, with a full pause between them
    random_phase(125);
    settle();
    idle_pct = 78;
    random_phase(125);
    settle();
    idle_pct = 0;
    random_phase(125);

    // wait for the tail of the last transaction and any late strobes
    settle();
    repeat (40) @(posedge clk);

    $display({"summary: %0d inserts (%0d refused when full), %0d deletes",
              " (%0d missing), %0d reports (%0d empty), %0d ignored"},
             sb.n_insert, sb.n_full, sb.n_delete, sb.n_missing, sb.n_report,
             sb.n_empty, sb.n_ignored);
    $display("summary: %0d results checked, peak fill %0d of %0d, %0d mismatches",
             sb.checked, sb.peak_fill, DEPTH, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
